// ===== hw/rtl/tnaa_pkg.sv =====
// Package with widths, payload types and pipeline metadata of the triangle normal and area unit.
package tnaa_pkg;

   localparam int COORD_BITS           = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 30;
   localparam int TAG_BITS             = 16;
   localparam int AREA_BITS            = 50;
   localparam int NORMAL_BITS          = 32;

   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = 2 * COORD_BITS + 1;
   localparam int LO_BITS    = (MAG_BITS + 1) / 2;
   localparam int HI_BITS    = MAG_BITS - LO_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tri_tag;
      coord_type           a_x;
      coord_type           a_y;
      coord_type           a_z;
      coord_type           b_x;
      coord_type           b_y;
      coord_type           b_z;
      coord_type           c_x;
      coord_type           c_y;
      coord_type           c_z;
   } req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]           out_tag;
      logic [AREA_BITS-1:0]          twice_area;
      logic signed [NORMAL_BITS-1:0] normal_x;
      logic signed [NORMAL_BITS-1:0] normal_y;
      logic signed [NORMAL_BITS-1:0] normal_z;
      logic                          degenerate;
   } rsp_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic                degenerate;
      logic [2:0]          neg;
   } meta_type;

   typedef struct packed {
      meta_type            meta;
      logic [SUM_BITS-1:0] sum;
      logic [SQ_BITS-1:0]  sq_x;
      logic [SQ_BITS-1:0]  sq_y;
      logic [SQ_BITS-1:0]  sq_z;
   } front_type;

endpackage

// ===== hw/rtl/tnaa_front.sv =====
// Front pipeline: edge vectors, cross product, component squares and their sum.
module tnaa_front import tnaa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      in_valid,
   input  req_type   in_data,
   output logic      out_valid,
   output front_type out_data
);

   localparam int STAGES = 6;

   logic [STAGES-1:0] valid_ff, valid_in;
   meta_type meta_ff [STAGES];
   meta_type meta_in [STAGES];

   logic signed [EDGE_BITS-1:0]  e1_ff [3], e1_in [3], e2_ff [3], e2_in [3];
   logic signed [PROD_BITS-1:0]  p_ff [6], p_in [6];
   logic signed [CROSS_BITS-1:0] xprod [3];
   logic [2:0]                   neg_in;
   logic [MAG_BITS-1:0]          mag_ff [3], mag_in [3];
   logic [2*HI_BITS-1:0]         hh_ff [3], hh_in [3];
   logic [HI_BITS+LO_BITS-1:0]   hl_ff [3], hl_in [3];
   logic [2*LO_BITS-1:0]         ll_ff [3], ll_in [3];
   logic [SQ_BITS-1:0]           sq_ff [3], sq_in [3];
   logic [SQ_BITS-1:0]           sqo_ff [3];
   logic [SUM_BITS-1:0]          sum_ff, sum_in;

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_comb begin
      e1_in[0] = EDGE_BITS'(in_data.b_x) - EDGE_BITS'(in_data.a_x);
      e1_in[1] = EDGE_BITS'(in_data.b_y) - EDGE_BITS'(in_data.a_y);
      e1_in[2] = EDGE_BITS'(in_data.b_z) - EDGE_BITS'(in_data.a_z);
      e2_in[0] = EDGE_BITS'(in_data.c_x) - EDGE_BITS'(in_data.a_x);
      e2_in[1] = EDGE_BITS'(in_data.c_y) - EDGE_BITS'(in_data.a_y);
      e2_in[2] = EDGE_BITS'(in_data.c_z) - EDGE_BITS'(in_data.a_z);

      p_in[0] = PROD_BITS'(e1_ff[1]) * PROD_BITS'(e2_ff[2]);
      p_in[1] = PROD_BITS'(e1_ff[2]) * PROD_BITS'(e2_ff[1]);
      p_in[2] = PROD_BITS'(e1_ff[2]) * PROD_BITS'(e2_ff[0]);
      p_in[3] = PROD_BITS'(e1_ff[0]) * PROD_BITS'(e2_ff[2]);
      p_in[4] = PROD_BITS'(e1_ff[0]) * PROD_BITS'(e2_ff[1]);
      p_in[5] = PROD_BITS'(e1_ff[1]) * PROD_BITS'(e2_ff[0]);

      for (int i = 0; i < 3; i++) begin
         xprod[i]  = CROSS_BITS'(p_ff[2*i]) - CROSS_BITS'(p_ff[2*i+1]);
         neg_in[i] = xprod[i][CROSS_BITS-1];
         mag_in[i] = neg_in[i] ? MAG_BITS'(-xprod[i]) : MAG_BITS'(xprod[i]);
         hh_in[i]  = (2*HI_BITS)'(mag_ff[i][MAG_BITS-1:LO_BITS])
                     * (2*HI_BITS)'(mag_ff[i][MAG_BITS-1:LO_BITS]);
         hl_in[i]  = (HI_BITS+LO_BITS)'(mag_ff[i][MAG_BITS-1:LO_BITS])
                     * (HI_BITS+LO_BITS)'(mag_ff[i][LO_BITS-1:0]);
         ll_in[i]  = (2*LO_BITS)'(mag_ff[i][LO_BITS-1:0])
                     * (2*LO_BITS)'(mag_ff[i][LO_BITS-1:0]);
         sq_in[i]  = (SQ_BITS'(hh_ff[i]) << (2*LO_BITS))
                     + (SQ_BITS'(hl_ff[i]) << (LO_BITS+1))
                     + SQ_BITS'(ll_ff[i]);
      end

      sum_in = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);

      meta_in[0] = '{tag: in_data.tri_tag, degenerate: 1'b0, neg: 3'b000};
      meta_in[1] = meta_ff[0];
      meta_in[2] = meta_ff[1];
      meta_in[2].neg = neg_in;
      meta_in[3] = meta_ff[2];
      meta_in[4] = meta_ff[3];
      meta_in[5] = meta_ff[4];
      meta_in[5].degenerate = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         meta_ff <= meta_in;
         e1_ff   <= e1_in;
         e2_ff   <= e2_in;
         p_ff    <= p_in;
         mag_ff  <= mag_in;
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         sq_ff   <= sq_in;
         sqo_ff  <= sq_ff;
         sum_ff  <= sum_in;
      end
   end

   assign out_valid     = valid_ff[STAGES-1];
   assign out_data.meta = meta_ff[STAGES-1];
   assign out_data.sum  = sum_ff;
   assign out_data.sq_x = sqo_ff[0];
   assign out_data.sq_y = sqo_ff[1];
   assign out_data.sq_z = sqo_ff[2];

endmodule

// ===== hw/rtl/tnaa_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for three numerators over one divisor.
module tnaa_div import tnaa_pkg::*; #(
   parameter int FRAC_BITS = NORMAL_FRAC_BITS_DEF,
   localparam int QUO_BITS = 2 * FRAC_BITS + 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  front_type           in_data,
   output logic                out_valid,
   output meta_type            out_meta,
   output logic [SUM_BITS-1:0] out_sum,
   output logic [QUO_BITS-1:0] out_quo [3]
);

   localparam int STAGES = QUO_BITS;

   logic [STAGES-1:0]   valid_ff;
   meta_type            meta_ff [STAGES];
   logic [SUM_BITS-1:0] div_ff [STAGES];
   logic [SUM_BITS-1:0] rem_ff [STAGES][3];
   logic [QUO_BITS-1:0] quo_ff [STAGES][3];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                src_valid;
      meta_type            src_meta;
      logic [SUM_BITS-1:0] src_div;
      logic [SUM_BITS-1:0] src_rem [3];
      logic [QUO_BITS-1:0] src_quo [3];
      logic [SUM_BITS:0]   num [3];
      logic [2:0]          ge;
      logic [SUM_BITS-1:0] rem_in [3];
      logic [QUO_BITS-1:0] quo_in [3];

      if (k == 0) begin : g_first
         assign src_valid  = in_valid;
         assign src_meta   = in_data.meta;
         assign src_div    = in_data.sum;
         assign src_rem[0] = SUM_BITS'(in_data.sq_x);
         assign src_rem[1] = SUM_BITS'(in_data.sq_y);
         assign src_rem[2] = SUM_BITS'(in_data.sq_z);
         assign src_quo[0] = '0;
         assign src_quo[1] = '0;
         assign src_quo[2] = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_meta  = meta_ff[k-1];
         assign src_div   = div_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_quo   = quo_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            num[i]    = (k == 0) ? {1'b0, src_rem[i]} : {src_rem[i], 1'b0};
            ge[i]     = num[i] >= {1'b0, src_div};
            rem_in[i] = ge[i] ? SUM_BITS'(num[i] - {1'b0, src_div}) : SUM_BITS'(num[i]);
            quo_in[i] = {src_quo[i][QUO_BITS-2:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            meta_ff[k] <= src_meta;
            div_ff[k]  <= src_div;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_meta  = meta_ff[STAGES-1];
   assign out_sum   = div_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];

endmodule

// ===== hw/rtl/tnaa_sqrt.sv =====
// Pipelined restoring integer square root: one root bit per stage in each lane.
module tnaa_sqrt import tnaa_pkg::*; #(
   parameter int ROOT_BITS = 50,
   parameter int LANES     = 4,
   localparam int RAD_BITS = 2 * ROOT_BITS,
   localparam int REM_BITS = ROOT_BITS + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  meta_type             in_meta,
   input  logic [RAD_BITS-1:0]  in_rad [LANES],
   output logic                 out_valid,
   output meta_type             out_meta,
   output logic [ROOT_BITS-1:0] out_root [LANES],
   output logic [REM_BITS-1:0]  out_rem [LANES]
);

   localparam int STAGES = ROOT_BITS;

   logic [STAGES-1:0]    valid_ff;
   meta_type             meta_ff [STAGES];
   logic [RAD_BITS-1:0]  rad_ff [STAGES][LANES];
   logic [REM_BITS-1:0]  rem_ff [STAGES][LANES];
   logic [ROOT_BITS-1:0] root_ff [STAGES][LANES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                 src_valid;
      meta_type             src_meta;
      logic [RAD_BITS-1:0]  src_rad [LANES];
      logic [REM_BITS-1:0]  src_rem [LANES];
      logic [ROOT_BITS-1:0] src_root [LANES];
      logic [REM_BITS-1:0]  part [LANES];
      logic [REM_BITS-1:0]  trial [LANES];
      logic [LANES-1:0]     ge;
      logic [RAD_BITS-1:0]  rad_in [LANES];
      logic [REM_BITS-1:0]  rem_in [LANES];
      logic [ROOT_BITS-1:0] root_in [LANES];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_meta  = in_meta;
         assign src_rad   = in_rad;
         for (genvar j = 0; j < LANES; j++) begin : g_lane
            assign src_rem[j]  = '0;
            assign src_root[j] = '0;
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_meta  = meta_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
      end

      always_comb begin
         for (int j = 0; j < LANES; j++) begin
            part[j]    = {src_rem[j][ROOT_BITS-1:0], src_rad[j][RAD_BITS-1 -: 2]};
            trial[j]   = {src_root[j], 2'b01};
            ge[j]      = part[j] >= trial[j];
            rem_in[j]  = ge[j] ? part[j] - trial[j] : part[j];
            root_in[j] = {src_root[j][ROOT_BITS-2:0], ge[j]};
            rad_in[j]  = src_rad[j] << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            meta_ff[k] <= src_meta;
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_meta  = meta_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_rem   = rem_ff[STAGES-1];

endmodule

// ===== hw/rtl/triangle_normal_and_area_unit.sv =====
// Throughput: one triangle per cycle while the output is not stalled; the bit-per-stage
// divider and square root pipelines set the depth, and a full output register held by
// rsp_stall stalls every stage at once.
// One input holding register takes a transfer while the output waits.
// Synchronous reset clears all valid bits; payload registers are not reset.
module triangle_normal_and_area_unit import tnaa_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int QUO_BITS  = 2 * NORMAL_FRAC_BITS + 3;
   localparam int ROOT_BITS = (MAG_BITS + 1 > NORMAL_FRAC_BITS + 2) ?
                              MAG_BITS + 1 : NORMAL_FRAC_BITS + 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int AW        = (ROOT_BITS + 1 > AREA_BITS) ? ROOT_BITS + 1 : AREA_BITS;
   localparam logic signed [NORMAL_BITS-1:0] NORM_ONE  = NORMAL_BITS'(1) << NORMAL_FRAC_BITS;
   localparam logic signed [NORMAL_BITS-1:0] NORM_MONE = -NORM_ONE;

   logic    adv;
   logic    hold_valid_ff, hold_valid_in;
   req_type hold_data_ff, hold_data_in;
   logic    entry_valid;
   req_type entry_data;

   logic      front_valid;
   front_type front_data;

   logic                div_valid;
   meta_type            div_meta;
   logic [SUM_BITS-1:0] div_sum;
   logic [QUO_BITS-1:0] div_quo [3];

   logic [RAD_BITS-1:0]  sq_rad [4];
   logic                 sq_valid;
   meta_type             sq_meta;
   logic [ROOT_BITS-1:0] sq_root [4];
   logic [REM_BITS-1:0]  sq_rem [4];

   logic [AW-1:0]                 area_full;
   logic [ROOT_BITS:0]            half_up [3];
   logic signed [NORMAL_BITS-1:0] norm [3];
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   assign adv         = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = hold_valid_ff;
   assign entry_valid = hold_valid_ff || req_valid;
   assign entry_data  = hold_valid_ff ? hold_data_ff : req_data;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (adv) begin
         hold_valid_in = 1'b0;
      end else if (req_valid && !hold_valid_ff) begin
         hold_valid_in = 1'b1;
         hold_data_in  = req_data;
      end
   end

   tnaa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (entry_valid),
      .in_data   (entry_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   tnaa_div #(
      .FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_meta  (div_meta),
      .out_sum   (div_sum),
      .out_quo   (div_quo)
   );

   assign sq_rad[0] = RAD_BITS'(div_sum);
   assign sq_rad[1] = RAD_BITS'(div_quo[0]);
   assign sq_rad[2] = RAD_BITS'(div_quo[1]);
   assign sq_rad[3] = RAD_BITS'(div_quo[2]);

   tnaa_sqrt #(
      .ROOT_BITS (ROOT_BITS),
      .LANES     (4)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (div_valid),
      .in_meta   (div_meta),
      .in_rad    (sq_rad),
      .out_valid (sq_valid),
      .out_meta  (sq_meta),
      .out_root  (sq_root),
      .out_rem   (sq_rem)
   );

   always_comb begin
      area_full = AW'(sq_root[0]) + AW'(REM_BITS'(sq_rem[0]) > REM_BITS'(sq_root[0]));
      for (int i = 0; i < 3; i++) begin
         half_up[i] = (ROOT_BITS+1)'(sq_root[i+1]) + (ROOT_BITS+1)'(1);
         norm[i]    = NORMAL_BITS'(half_up[i][ROOT_BITS:1]);
         if (sq_meta.neg[i]) begin
            norm[i] = -norm[i];
         end
      end
      rsp_valid_in           = sq_valid;
      rsp_data_in.out_tag    = sq_meta.tag;
      rsp_data_in.degenerate = sq_meta.degenerate;
      rsp_data_in.twice_area = (area_full > AW'({AREA_BITS{1'b1}})) ?
                               {AREA_BITS{1'b1}} : AREA_BITS'(area_full);
      rsp_data_in.normal_x   = norm[0];
      rsp_data_in.normal_y   = norm[1];
      rsp_data_in.normal_z   = norm[2];
      if (sq_meta.degenerate) begin
         rsp_data_in.twice_area = '0;
         rsp_data_in.normal_x   = '0;
         rsp_data_in.normal_y   = '0;
         rsp_data_in.normal_z   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (adv) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_data_ff <= hold_data_in;
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_hold_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> $past(rsp_valid_ff && rsp_stall))
      else $error("Holding register filled while the pipeline was moving.");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.degenerate) |->
      (rsp_data_ff.twice_area == '0 && rsp_data_ff.normal_x == '0 &&
       rsp_data_ff.normal_y == '0 && rsp_data_ff.normal_z == '0))
      else $error("Degenerate triangle with nonzero result fields.");

   a_area_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.degenerate) |-> rsp_data_ff.twice_area != '0)
      else $error("Nondegenerate triangle with zero area.");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
      (rsp_data_ff.normal_x <= NORM_ONE && rsp_data_ff.normal_x >= NORM_MONE &&
       rsp_data_ff.normal_y <= NORM_ONE && rsp_data_ff.normal_y >= NORM_MONE &&
       rsp_data_ff.normal_z <= NORM_ONE && rsp_data_ff.normal_z >= NORM_MONE))
      else $error("Normal component outside the unit range.");

endmodule
